### hw/rtl/txrb_pkg.sv
// Shared constants and types of the transmit ring buffer DMA feeder.
`default_nettype none

package txrb_pkg;

  localparam int unsigned BufferBytes = 1024;
  localparam int unsigned IdxW        = $clog2(BufferBytes);
  localparam int unsigned LenW        = IdxW + 1;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned CmdW        = 2;

  localparam logic [CmdW-1:0] CmdBegin = 2'd0;
  localparam logic [CmdW-1:0] CmdByte  = 2'd1;
  localparam logic [CmdW-1:0] CmdDone  = 2'd2;
  localparam logic [CmdW-1:0] CmdFetch = 2'd3;

  typedef struct packed {
    logic take;
    logic load_item;
    logic load_fetch;
  } dp_cmd_t;

endpackage

`default_nettype wire

### hw/rtl/txrb_in_if.sv
// Input channel of the ring buffer: command items with handshake.
`default_nettype none

interface txrb_in_if;
  logic                          valid;
  logic                          ready;
  logic [txrb_pkg::CmdW-1:0]     command;
  logic [txrb_pkg::LenW-1:0]     length;
  logic [txrb_pkg::ByteW-1:0]    data_byte;
  logic [txrb_pkg::IdxW-1:0]     fetch_index;

  modport source (output valid, command, length, data_byte, fetch_index, input ready);
  modport sink (input valid, command, length, data_byte, fetch_index, output ready);
endinterface

`default_nettype wire

### hw/rtl/txrb_out_if.sv
// Output channel of the ring buffer: result items with handshake.
`default_nettype none

interface txrb_out_if;
  logic                          valid;
  logic                          ready;
  logic                          accepted;
  logic                          dma_start_valid;
  logic [txrb_pkg::IdxW-1:0]     dma_start_index;
  logic [txrb_pkg::LenW-1:0]     dma_length;
  logic [txrb_pkg::ByteW-1:0]    read_byte;

  modport source (output valid, accepted, dma_start_valid, dma_start_index, dma_length,
                  read_byte, input ready);
  modport sink (input valid, accepted, dma_start_valid, dma_start_index, dma_length,
                read_byte, output ready);
endinterface

`default_nettype wire

### hw/rtl/txrb_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module txrb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/txrb_ctrl.sv
// Controller of the ring buffer: item handshake, fetch wait state and result valid.
`default_nettype none

module txrb_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_is_fetch_i,
  output logic                   in_ready_o,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output txrb_pkg::dp_cmd_t      cmd_o
);

  localparam logic StIdle  = 1'b0;
  localparam logic StFetch = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic take;

  assign in_ready_o = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign take       = in_valid_i && in_ready_o;

  assign cmd_o.take       = take;
  assign cmd_o.load_item  = take && !in_is_fetch_i;
  assign cmd_o.load_fetch = (state_q == StFetch);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (take && in_is_fetch_i) begin
          state_d = StFetch;
        end
      end
      StFetch: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_item || cmd_o.load_fetch) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_fetch_one_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StFetch |=> state_q == StIdle)
    else $error("fetch wait state lasted more than one cycle");

  a_fetch_slot_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StFetch |-> !out_valid_q)
    else $error("fetch result would overwrite a pending result");

  a_fetch_enters_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && in_is_fetch_i |=> state_q == StFetch && !in_ready_o)
    else $error("fetch item did not enter the wait state");

endmodule

`default_nettype wire

### hw/rtl/txrb_dp.sv
// Datapath of the ring buffer: indices, message tracking, byte store and result register.
`default_nettype none

module txrb_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire txrb_pkg::dp_cmd_t             cmd_i,
  input  wire logic [txrb_pkg::CmdW-1:0]     command_i,
  input  wire logic [txrb_pkg::LenW-1:0]     length_i,
  input  wire logic [txrb_pkg::ByteW-1:0]    data_byte_i,
  input  wire logic [txrb_pkg::IdxW-1:0]     fetch_index_i,
  output logic                               accepted_o,
  output logic                               dma_start_valid_o,
  output logic      [txrb_pkg::IdxW-1:0]     dma_start_index_o,
  output logic      [txrb_pkg::LenW-1:0]     dma_length_o,
  output logic      [txrb_pkg::ByteW-1:0]    read_byte_o
);

  logic [txrb_pkg::IdxW-1:0] wr_idx_q, wr_idx_d;
  logic [txrb_pkg::IdxW-1:0] rd_idx_q, rd_idx_d;
  logic                      busy_q, busy_d;
  logic [txrb_pkg::LenW-1:0] left_q, left_d;
  logic                      taken_q, taken_d;

  logic [txrb_pkg::IdxW-1:0] used;
  logic [txrb_pkg::LenW:0]   space_sum;
  logic                      begin_ok;
  logic [txrb_pkg::LenW-1:0] left_dec;
  logic                      byte_live;
  logic                      byte_store_we;
  logic [txrb_pkg::IdxW-1:0] wr_next, rd_next;
  logic [txrb_pkg::LenW-1:0] seg_len;
  logic                      try_start;
  logic                      start;
  logic [txrb_pkg::ByteW-1:0] ram_rdata;

  logic                      accepted_q, accepted_d;
  logic                      start_valid_q, start_valid_d;
  logic [txrb_pkg::IdxW-1:0] start_index_q, start_index_d;
  logic [txrb_pkg::LenW-1:0] dma_len_q, dma_len_d;
  logic [txrb_pkg::ByteW-1:0] read_byte_q;

  assign used      = wr_idx_q - rd_idx_q;
  assign space_sum = {2'b00, used} + {1'b0, length_i};
  assign begin_ok  = (length_i != '0) &&
                     (space_sum < (txrb_pkg::LenW + 1)'(txrb_pkg::BufferBytes));

  assign left_dec      = left_q - 1'b1;
  assign byte_live     = (command_i == txrb_pkg::CmdByte) && (left_q != '0);
  assign byte_store_we = cmd_i.take && byte_live && taken_q;

  always_comb begin
    wr_next   = wr_idx_q;
    rd_next   = rd_idx_q;
    try_start = 1'b0;
    if (command_i == txrb_pkg::CmdByte) begin
      if (byte_live && taken_q) begin
        wr_next   = wr_idx_q + 1'b1;
        try_start = (left_dec == '0) && !busy_q;
      end
    end else if (command_i == txrb_pkg::CmdDone) begin
      if (busy_q) begin
        rd_next   = rd_idx_q + length_i[txrb_pkg::IdxW-1:0];
        try_start = 1'b1;
      end
    end
  end

  always_comb begin
    if (wr_next > rd_next) begin
      seg_len = {1'b0, wr_next - rd_next};
    end else if (wr_next < rd_next) begin
      seg_len = txrb_pkg::LenW'(txrb_pkg::BufferBytes) - {1'b0, rd_next};
    end else begin
      seg_len = '0;
    end
  end

  assign start = try_start && (seg_len != '0);

  always_comb begin
    wr_idx_d = wr_idx_q;
    rd_idx_d = rd_idx_q;
    busy_d   = busy_q;
    left_d   = left_q;
    taken_d  = taken_q;
    if (cmd_i.load_item) begin
      wr_idx_d = wr_next;
      rd_idx_d = rd_next;
      if (try_start) begin
        busy_d = start;
      end
      case (command_i)
        txrb_pkg::CmdBegin: begin
          left_d  = length_i;
          taken_d = begin_ok;
        end
        txrb_pkg::CmdByte: begin
          if (byte_live) begin
            left_d = left_dec;
            if (left_dec == '0) begin
              taken_d = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      rd_idx_q <= '0;
      busy_q   <= 1'b0;
      left_q   <= '0;
      taken_q  <= 1'b0;
    end else begin
      wr_idx_q <= wr_idx_d;
      rd_idx_q <= rd_idx_d;
      busy_q   <= busy_d;
      left_q   <= left_d;
      taken_q  <= taken_d;
    end
  end

  txrb_ram #(
    .Width (txrb_pkg::ByteW),
    .Depth (txrb_pkg::BufferBytes)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (byte_store_we),
    .waddr_i (wr_idx_q),
    .wdata_i (data_byte_i),
    .re_i    (cmd_i.take && (command_i == txrb_pkg::CmdFetch)),
    .raddr_i (fetch_index_i),
    .rdata_o (ram_rdata)
  );

  assign accepted_d    = (command_i == txrb_pkg::CmdBegin) && begin_ok;
  assign start_valid_d = start;
  assign start_index_d = start ? rd_next : '0;
  assign dma_len_d     = start ? seg_len : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      accepted_q    <= accepted_d;
      start_valid_q <= start_valid_d;
      start_index_q <= start_index_d;
      dma_len_q     <= dma_len_d;
      read_byte_q   <= '0;
    end else if (cmd_i.load_fetch) begin
      accepted_q    <= 1'b0;
      start_valid_q <= 1'b0;
      start_index_q <= '0;
      dma_len_q     <= '0;
      read_byte_q   <= ram_rdata;
    end
  end

  assign accepted_o        = accepted_q;
  assign dma_start_valid_o = start_valid_q;
  assign dma_start_index_o = start_index_q;
  assign dma_length_o      = dma_len_q;
  assign read_byte_o       = read_byte_q;

endmodule

`default_nettype wire

### hw/rtl/tx_ring_buffer_dma_feeder.sv
// Top level of the transmit ring buffer that feeds a DMA engine.
//
//   Channel  Direction  Carries
//   req_i    in         command, length, data_byte, fetch_index
//   rsp_o    out        accepted, dma_start_valid, dma_start_index, dma_length, read_byte
//
// Begin, byte and transfer-done items load the result register when taken; a fetch item
// first passes a wait state, as the read port of the byte store is registered.
// Every item gives exactly one result item, held in a single output register.
// Outside the fetch wait state, a new item is taken while the held result is being taken in the same cycle.
// Reset clears indices, message state and DMA state; the store itself is not cleared.
`default_nettype none

module tx_ring_buffer_dma_feeder (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  txrb_in_if.sink    req_i,
  txrb_out_if.source rsp_o
);

  txrb_pkg::dp_cmd_t dp_cmd;

  txrb_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (req_i.valid),
    .in_is_fetch_i (req_i.command == txrb_pkg::CmdFetch),
    .in_ready_o    (req_i.ready),
    .out_ready_i   (rsp_o.ready),
    .out_valid_o   (rsp_o.valid),
    .cmd_o         (dp_cmd)
  );

  txrb_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (dp_cmd),
    .command_i         (req_i.command),
    .length_i          (req_i.length),
    .data_byte_i       (req_i.data_byte),
    .fetch_index_i     (req_i.fetch_index),
    .accepted_o        (rsp_o.accepted),
    .dma_start_valid_o (rsp_o.dma_start_valid),
    .dma_start_index_o (rsp_o.dma_start_index),
    .dma_length_o      (rsp_o.dma_length),
    .read_byte_o       (rsp_o.read_byte)
  );

endmodule

`default_nettype wire
